[src/bmsd_pkg.sv]
`default_nettype none
package bmsd_pkg;

    localparam int FRAME_BYTES = 13;
    localparam int MAX_SENSORS = 7;
    localparam int REC_W       = 3;
    localparam int DIV_W       = 24;

    // record kinds
    localparam logic [3:0] KIND_SOC     = 4'd0;
    localparam logic [3:0] KIND_MINMAX  = 4'd1;
    localparam logic [3:0] KIND_FETS    = 4'd2;
    localparam logic [3:0] KIND_COUNTS  = 4'd3;
    localparam logic [3:0] KIND_CELL    = 4'd4;
    localparam logic [3:0] KIND_TEMP    = 4'd5;
    localparam logic [3:0] KIND_BALANCE = 4'd6;
    localparam logic [3:0] KIND_FAULTS  = 4'd7;
    localparam logic [3:0] KIND_CSUM    = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN = 4'd9;

    // command offsets from command_base
    localparam logic [7:0] OFF_SOC     = 8'd0;
    localparam logic [7:0] OFF_MINMAX  = 8'd1;
    localparam logic [7:0] OFF_TEMPMM  = 8'd2;
    localparam logic [7:0] OFF_FETS    = 8'd3;
    localparam logic [7:0] OFF_COUNTS  = 8'd4;
    localparam logic [7:0] OFF_CELLS   = 8'd5;
    localparam logic [7:0] OFF_TEMPS   = 8'd6;
    localparam logic [7:0] OFF_BALANCE = 8'd7;
    localparam logic [7:0] OFF_FAULTS  = 8'd8;

    // register indexes
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam logic [7:0]  TEMP_BIAS  = 8'd40;
    localparam logic [16:0] SOC_ROUND  = 17'd5;
    // x * 52429 >> 19 equals x / 10 for every x below 87381
    localparam logic [16:0] SOC_RECIP  = 17'd52429;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  index_a;
        logic [7:0]  index_b;
        logic [16:0] value_a;
        logic [16:0] value_b;
        logic [15:0] value_c;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic capture_in;
        logic do_step;
        logic clear_rec;
        logic load_err;
        logic div_start;
        logic load_rec;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic sum_ok;
        logic need_div;
        logic rec_last;
        logic div_done;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[src/bmsd_divider.sv]
`default_nettype none
module bmsd_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [bmsd_pkg::DIV_W-1:0]   dividend,
    input  wire logic [7:0]                   divisor,
    output logic      [bmsd_pkg::DIV_W-1:0]   quotient,
    output logic                              busy,
    output logic                              done
);
    localparam int CNT_W = $clog2(bmsd_pkg::DIV_W + 1);

    logic [bmsd_pkg::DIV_W-1:0] q_reg, q_next;
    logic [7:0]                 rem_reg, rem_next;
    logic [7:0]                 dvs_reg, dvs_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [8:0]                 trial;

    // one restoring step per cycle
    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {rem_reg, q_reg[bmsd_pkg::DIV_W-1]};
        if (start) begin
            q_next    = dividend;
            rem_next  = 8'd0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 8'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[bmsd_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[7:0];
                q_next   = {q_reg[bmsd_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bmsd_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

[src/bmsd_datapath.sv]
`default_nettype none
module bmsd_datapath #(
    parameter int MAX_SENSORS = bmsd_pkg::MAX_SENSORS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_op,
    input  wire logic [7:0]        in_byte,
    input  wire bmsd_pkg::cmd_t    cmd,
    output bmsd_pkg::sts_t         sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output bmsd_pkg::rec_t         out_rec
);
    logic [7:0]  start_reg, base_reg;
    logic [15:0] offset_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic        coll_reg, coll_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  fs_reg [bmsd_pkg::FRAME_BYTES];
    logic [7:0]  ctot_reg, ctot_next;
    logic [7:0]  stot_reg, stot_next;
    logic [7:0]  cidx_reg, cidx_next;
    logic [23:0] vsum_reg, vsum_next;
    logic [bmsd_pkg::REC_W-1:0] rec_reg;
    logic        ovalid_reg;
    bmsd_pkg::rec_t orec_reg;
    bmsd_pkg::rec_t rec;
    logic        need_div;
    logic [23:0] div_dvd;
    logic [7:0]  div_dvs;
    logic [23:0] quot;
    logic        div_busy, div_done;
    logic [7:0]  off;
    logic [15:0] w4, w7, w8, w10;
    logic [15:0] cell_v;
    logic [23:0] new_sum;
    logic [7:0]  new_idx;
    logic        hit;
    logic [12:0] fmask;
    logic        out_free;
    logic [34:0] soc_prod;

    assign w4  = {fs_reg[4], fs_reg[5]};
    assign w7  = {fs_reg[7], fs_reg[8]};
    assign w8  = {fs_reg[8], fs_reg[9]};
    assign w10 = {fs_reg[10], fs_reg[11]};
    assign off = fs_reg[2] - base_reg;
    assign out_free = !ovalid_reg || out_ready;

    // configuration and input capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= 8'd165;
            base_reg   <= 8'd144;
            offset_reg <= 16'd30000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bmsd_pkg::REG_START:  start_reg  <= cfg_wdata[7:0];
                bmsd_pkg::REG_BASE:   base_reg   <= cfg_wdata[7:0];
                bmsd_pkg::REG_OFFSET: offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
        if (cmd.capture_in) begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
        end
    end

    // frame collection
    always_comb begin
        coll_next  = coll_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (cmd.do_step) begin
            if (op_reg) begin
                coll_next  = 1'b0;
                count_next = 4'd0;
                sum_next   = 8'd0;
            end else if (!coll_reg) begin
                if (byte_reg == start_reg) begin
                    coll_next  = 1'b1;
                    count_next = 4'd1;
                    sum_next   = byte_reg;
                end
            end else if (count_reg < 4'(bmsd_pkg::FRAME_BYTES - 1)) begin
                count_next = count_reg + 4'd1;
                sum_next   = sum_reg + byte_reg;
            end else begin
                coll_next  = 1'b0;
                count_next = 4'd0;
                sum_next   = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_step && !op_reg) begin
            if (!coll_reg) begin
                if (byte_reg == start_reg) fs_reg[0] <= byte_reg;
            end else if (count_reg < 4'(bmsd_pkg::FRAME_BYTES)) begin
                fs_reg[count_reg] <= byte_reg;
            end
        end
    end

    // fault mask folding
    always_comb begin
        fmask = '0;
        for (int p = 0; p < 4; p++) begin
            fmask[p]     = |fs_reg[4][2*p +: 2];
            fmask[4 + p] = |fs_reg[5][2*p +: 2];
        end
        fmask[8]  = |fs_reg[6][1:0];
        fmask[9]  = |fs_reg[6][3:2];
        fmask[10] = fs_reg[10][2];
        fmask[12] = (|fs_reg[6][7:4]) | (|fs_reg[7][3:0]) | (|fs_reg[8])
                  | (|fs_reg[9]) | (|(fs_reg[10] & 8'h0B));
    end

    // cell step values
    always_comb begin
        unique case (rec_reg)
            3'd0:    cell_v = {fs_reg[5], fs_reg[6]};
            3'd1:    cell_v = {fs_reg[7], fs_reg[8]};
            default: cell_v = {fs_reg[9], fs_reg[10]};
        endcase
    end
    assign new_sum = vsum_reg + {8'd0, cell_v};
    assign new_idx = cidx_reg + 8'd1;
    assign hit     = (ctot_reg != 8'd0) && (new_idx == ctot_reg);

    // charge percent by reciprocal multiply
    assign soc_prod = ({19'd0, w10} + 35'(bmsd_pkg::SOC_ROUND))
                    * 35'(bmsd_pkg::SOC_RECIP);

    // record decode
    always_comb begin
        rec      = '0;
        need_div = 1'b0;
        div_dvd  = new_sum;
        div_dvs  = ctot_reg;
        rec.last = 1'b1;
        if (fs_reg[2] < base_reg || off > bmsd_pkg::OFF_FAULTS
                || off == bmsd_pkg::OFF_TEMPMM) begin
            rec.kind    = bmsd_pkg::KIND_UNKNOWN;
            rec.index_a = fs_reg[2];
        end else begin
            unique case (off)
                bmsd_pkg::OFF_SOC: begin
                    rec.kind    = bmsd_pkg::KIND_SOC;
                    rec.value_a = {1'b0, w4};
                    rec.value_b = {1'b0, w8} - {1'b0, offset_reg};
                    rec.value_c = soc_prod[34:19];
                end
                bmsd_pkg::OFF_MINMAX: begin
                    rec.kind    = bmsd_pkg::KIND_MINMAX;
                    rec.index_a = fs_reg[6];
                    rec.index_b = fs_reg[9];
                    rec.value_a = {1'b0, w4};
                    rec.value_b = {1'b0, w7};
                    rec.value_c = (w4 >= w7) ? w4 - w7 : 16'd0;
                end
                bmsd_pkg::OFF_FETS: begin
                    rec.kind    = bmsd_pkg::KIND_FETS;
                    rec.value_a = {16'd0, fs_reg[5] == 8'd1};
                    rec.value_b = {16'd0, fs_reg[6] == 8'd1};
                end
                bmsd_pkg::OFF_COUNTS: begin
                    rec.kind    = bmsd_pkg::KIND_COUNTS;
                    rec.index_a = fs_reg[4];
                    rec.index_b = fs_reg[5];
                end
                bmsd_pkg::OFF_CELLS: begin
                    rec.kind    = bmsd_pkg::KIND_CELL;
                    rec.index_a = cidx_reg;
                    rec.value_a = {1'b0, cell_v};
                    rec.value_b = hit ? quot[16:0] : 17'd0;
                    rec.last    = hit || (rec_reg == 3'd2);
                    need_div    = hit;
                end
                bmsd_pkg::OFF_TEMPS: begin
                    rec.kind    = bmsd_pkg::KIND_TEMP;
                    rec.index_a = {5'd0, rec_reg};
                    rec.index_b = stot_reg;
                    rec.value_a = {9'd0, fs_reg[4'd5 + {1'b0, rec_reg}]}
                                - {9'd0, bmsd_pkg::TEMP_BIAS};
                    rec.last    = ({5'd0, rec_reg} + 8'd1 == stot_reg)
                               || (rec_reg == bmsd_pkg::REC_W'(MAX_SENSORS - 1));
                end
                bmsd_pkg::OFF_BALANCE: begin
                    rec.kind    = bmsd_pkg::KIND_BALANCE;
                    rec.value_a = {16'd0, (|fs_reg[4]) | (|fs_reg[5]) | (|fs_reg[6])
                                  | (|fs_reg[7]) | (|fs_reg[8]) | (|fs_reg[9])};
                end
                default: begin
                    rec.kind    = bmsd_pkg::KIND_FAULTS;
                    rec.value_a = {4'd0, fmask};
                end
            endcase
        end
    end

    // decoder state updates at record load
    always_comb begin
        ctot_next = ctot_reg;
        stot_next = stot_reg;
        cidx_next = cidx_reg;
        vsum_next = vsum_reg;
        if (cmd.load_rec && rec.kind == bmsd_pkg::KIND_COUNTS) begin
            ctot_next = fs_reg[4];
            stot_next = fs_reg[5];
            cidx_next = 8'd0;
            vsum_next = 24'd0;
        end else if (cmd.load_rec && rec.kind == bmsd_pkg::KIND_CELL) begin
            cidx_next = hit ? 8'd0 : new_idx;
            vsum_next = hit ? 24'd0 : new_sum;
        end
    end

    bmsd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    // state, record counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coll_reg   <= 1'b0;
            count_reg  <= 4'd0;
            sum_reg    <= 8'd0;
            ctot_reg   <= 8'd0;
            stot_reg   <= 8'd0;
            cidx_reg   <= 8'd0;
            vsum_reg   <= 24'd0;
            rec_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            coll_reg  <= coll_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ctot_reg  <= ctot_next;
            stot_reg  <= stot_next;
            cidx_reg  <= cidx_next;
            vsum_reg  <= vsum_next;
            if (cmd.clear_rec) rec_reg <= '0;
            else if (cmd.load_rec) rec_reg <= rec_reg + 1'b1;
            if (cmd.load_err || cmd.load_rec) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
        if (cmd.load_err) begin
            orec_reg      <= '0;
            orec_reg.kind <= bmsd_pkg::KIND_CSUM;
            orec_reg.last <= 1'b1;
        end else if (cmd.load_rec) begin
            orec_reg <= rec;
        end
    end

    always_comb begin
        sts.frame_end = !op_reg && coll_reg
                     && (count_reg == 4'(bmsd_pkg::FRAME_BYTES - 1));
        sts.sum_ok    = (sum_reg == byte_reg);
        sts.need_div  = need_div;
        sts.rec_last  = rec.last;
        sts.div_done  = div_done;
        sts.div_busy  = div_busy;
        sts.out_free  = out_free;
    end

    assign out_valid = ovalid_reg;
    assign out_rec   = orec_reg;
endmodule
`default_nettype wire

[src/bmsd_ctrl.sv]
`default_nettype none
module bmsd_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bmsd_pkg::sts_t  sts,
    output bmsd_pkg::cmd_t       cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    // sequencing of one received byte
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture_in = 1'b1;
                    state_next     = S_STEP;
                end
            end
            S_STEP: begin
                cmd.do_step   = 1'b1;
                cmd.clear_rec = 1'b1;
                if (sts.frame_end) state_next = sts.sum_ok ? S_DEC : S_ERR;
                else state_next = S_IDLE;
            end
            S_ERR: begin
                if (sts.out_free) begin
                    cmd.load_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DEC: begin
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_DIV: begin
                if (sts.div_done) state_next = S_PUT;
            end
            S_PUT: begin
                if (sts.out_free) begin
                    cmd.load_rec = 1'b1;
                    state_next   = sts.rec_last ? S_IDLE : S_DEC;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

[src/bms_reply_frame_decoder.sv]
`default_nettype none
// channel | dir | tdata (low bit up)                       | tuser | tlast
// s_      | in  | rx_byte[7:0]                             | op    | -
// m_      | out | kind, index_a, index_b, value_a, value_b, | -     | last
//         |     | value_c (70 bits, zero filled to 72)     |       |
// a byte that does not close a frame is captured in S_IDLE and stepped in
// S_STEP before the next is accepted; a closing byte also takes each record
// through S_DEC and S_PUT, the cell average through the 24-step divider
// aresetn is synchronous, active low; it restores the register defaults
// a stalled result holds in the output register; the next byte is taken once
// the last record of a frame is loaded
module bms_reply_frame_decoder #(
    parameter int MAX_SENSORS = bmsd_pkg::MAX_SENSORS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // kind, index_a, index_b, value_a, value_b, value_c
    output logic             m_tlast    // last
);
    bmsd_pkg::cmd_t cmd;
    bmsd_pkg::sts_t sts;
    bmsd_pkg::rec_t orec;

    bmsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmsd_datapath #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_rec   (orec)
    );

    assign m_tdata = {2'b00, orec.value_c, orec.value_b, orec.value_a,
                      orec.index_b, orec.index_a, orec.kind};
    assign m_tlast = orec.last;

    // loads only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_rec || cmd.load_err) |-> sts.out_free)
        else $error("record loaded over a pending result");

    // divider idle whenever a byte can be taken
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.div_busy)
        else $error("divider busy while accepting");

    // a fresh division never reports done at once
    a_div_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("stale divider done");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");
endmodule
`default_nettype wire
